@@ sv/mrp_pkg.sv @@
// Package for the motion report pacer: phase encoding, report identifiers,
// register indexes, the key map configuration struct and fixed limits.
// No dependencies.
`default_nettype none

package mrp_pkg;

	// Number of key positions examined when the shortcut mask is built.
	localparam int NUM_KEYS = 6;

	localparam int KEY_WIDTH    = 6;
	localparam int AXIS_WIDTH   = 16;
	localparam int TIME_WIDTH   = 32;
	localparam int MASK_WIDTH   = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int KILL_W       = 4;
	localparam int COUNT_W      = 8;

	// A group is treated as still once this many all-zero motion reports went out.
	localparam logic [COUNT_W-1:0] STILL_LIMIT = 8'd3;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

	typedef enum logic [1:0] {
		PH_INIT   = 2'd0,
		PH_IDLE   = 2'd1,
		PH_MOTION = 2'd2,
		PH_KEYS   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RID_NONE   = 2'd0,
		RID_MOTION = 2'd1,
		RID_SPARE  = 2'd2,
		RID_KEYS   = 2'd3
	} report_id_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERVAL   = 3'd0,
		CFG_KEY_R      = 3'd1,
		CFG_KEY_L      = 3'd2,
		CFG_KEY_TWO    = 3'd3,
		CFG_KEY_ONE    = 3'd4,
		CFG_KILL_ROT   = 3'd5,
		CFG_KILL_TRANS = 3'd6,
		CFG_UNUSED     = 3'd7
	} cfg_index_t;

	// Key map settings handed to the mask builder.
	typedef struct packed {
		logic [7:0]        key_r_bit;
		logic [7:0]        key_l_bit;
		logic [7:0]        key_two_bit;
		logic [7:0]        key_one_bit;
		logic [KILL_W-1:0] kill_rot_index;
		logic [KILL_W-1:0] kill_trans_index;
	} keycfg_t;

endpackage

`default_nettype wire

@@ sv/motion_report_pacer.sv @@
// Top level of the motion report pacer: input register, pacing state machine,
// result register and configuration registers. Depends on mrp_pkg and mrp_keymap.
`default_nettype none

// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// poll in   | in_valid, in_stall, now_ms, axes, keys   | into block
// report    | out_valid, out_stall, sent .. key_mask   | out of block
// config    | cfg_we, cfg_index, cfg_data              | into block
//
// Every poll word gives exactly one report word. A word that is accepted is
// held in the input register, evaluated against the pacing state and moved
// into the result register when that register advances, so one word can be
// taken in every cycle while the report side does not stall.
// The input register keeps taking words while the result register is full and
// stalled, until it is occupied itself. Reset returns the state machine to its
// initial phase and loads the configuration defaults; it needs no sweep.

module motion_report_pacer
	import mrp_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic        [TIME_WIDTH-1:0]  now_ms,
	input  wire logic signed [AXIS_WIDTH-1:0]  move_x,
	input  wire logic signed [AXIS_WIDTH-1:0]  move_y,
	input  wire logic signed [AXIS_WIDTH-1:0]  move_z,
	input  wire logic signed [AXIS_WIDTH-1:0]  turn_x,
	input  wire logic signed [AXIS_WIDTH-1:0]  turn_y,
	input  wire logic signed [AXIS_WIDTH-1:0]  turn_z,
	input  wire logic        [KEY_WIDTH-1:0]   keys_pressed,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               sent,
	output logic             [1:0]             report_id,
	output logic signed      [AXIS_WIDTH-1:0]  out_move_x,
	output logic signed      [AXIS_WIDTH-1:0]  out_move_y,
	output logic signed      [AXIS_WIDTH-1:0]  out_move_z,
	output logic signed      [AXIS_WIDTH-1:0]  out_turn_x,
	output logic signed      [AXIS_WIDTH-1:0]  out_turn_y,
	output logic signed      [AXIS_WIDTH-1:0]  out_turn_z,
	output logic             [MASK_WIDTH-1:0]  key_mask,

	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [7:0] interval_q;
	keycfg_t    keycfg_q;

	// Input register.
	logic                         valid_s1;
	logic        [TIME_WIDTH-1:0] now_s1;
	logic signed [AXIS_WIDTH-1:0] move_x_s1, move_y_s1, move_z_s1;
	logic signed [AXIS_WIDTH-1:0] turn_x_s1, turn_y_s1, turn_z_s1;
	logic        [KEY_WIDTH-1:0]  keys_s1;

	// Pacing state.
	phase_t                 phase_q, phase_d;
	logic [TIME_WIDTH-1:0]  last_q, last_d;
	logic [COUNT_W-1:0]     still_move_q, still_move_d;
	logic [COUNT_W-1:0]     still_turn_q, still_turn_d;
	logic [MASK_WIDTH-1:0]  prev_mask_q, prev_mask_d;

	// Result register.
	logic                         out_valid_q;
	logic                         sent_q;
	report_id_t                   report_id_q;
	logic signed [AXIS_WIDTH-1:0] o_mx_q, o_my_q, o_mz_q, o_tx_q, o_ty_q, o_tz_q;
	logic        [MASK_WIDTH-1:0] key_mask_q;

	// Combinational results for the word in the input register.
	logic                  sent_c;
	report_id_t            report_id_c;
	logic                  axes_on_c;
	logic                  mask_on_c;

	logic                  advance;
	logic                  in_accept;
	logic [MASK_WIDTH-1:0] mask;
	logic                  move_zero, turn_zero;
	logic                  motion_pending, mask_changed;
	logic [TIME_WIDTH-1:0] gap, pulled_time, last_eff;
	logic                  pulled, due;

	// The result register moves on when it is empty or being taken.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q                <= 8'd8;
			keycfg_q.key_r_bit        <= 8'd0;
			keycfg_q.key_l_bit        <= 8'd1;
			keycfg_q.key_two_bit      <= 8'd2;
			keycfg_q.key_one_bit      <= 8'd3;
			keycfg_q.kill_rot_index   <= 4'd4;
			keycfg_q.kill_trans_index <= 4'd5;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_INTERVAL:   interval_q                <= cfg_data;
				CFG_KEY_R:      keycfg_q.key_r_bit        <= cfg_data;
				CFG_KEY_L:      keycfg_q.key_l_bit        <= cfg_data;
				CFG_KEY_TWO:    keycfg_q.key_two_bit      <= cfg_data;
				CFG_KEY_ONE:    keycfg_q.key_one_bit      <= cfg_data;
				CFG_KILL_ROT:   keycfg_q.kill_rot_index   <= cfg_data[KILL_W-1:0];
				CFG_KILL_TRANS: keycfg_q.kill_trans_index <= cfg_data[KILL_W-1:0];
				CFG_UNUSED: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_s1    <= now_ms;
			move_x_s1 <= move_x;
			move_y_s1 <= move_y;
			move_z_s1 <= move_z;
			turn_x_s1 <= turn_x;
			turn_y_s1 <= turn_y;
			turn_z_s1 <= turn_z;
			keys_s1   <= keys_pressed;
		end
	end

	mrp_keymap u_keymap (
		.cfg  (keycfg_q),
		.keys (keys_s1),
		.mask (mask)
	);

	assign move_zero = move_x_s1 == '0 && move_y_s1 == '0 && move_z_s1 == '0;
	assign turn_zero = turn_x_s1 == '0 && turn_y_s1 == '0 && turn_z_s1 == '0;

	// Motion keeps going while either group has not yet sent three still reports or the word carries motion.
	assign motion_pending = still_move_q < STILL_LIMIT || still_turn_q < STILL_LIMIT
		|| !move_zero || !turn_zero;
	assign mask_changed   = mask != prev_mask_q;

	// Due check. When the gap has grown beyond twice the interval the send time
	// is pulled up to one interval behind now, which also makes the report due.
	assign gap         = now_s1 - last_q;
	assign pulled      = gap > TIME_WIDTH'({interval_q, 1'b0});
	assign pulled_time = now_s1 - TIME_WIDTH'(interval_q);
	assign due         = pulled || gap >= TIME_WIDTH'(interval_q);
	assign last_eff    = pulled ? pulled_time : last_q;

	// Next-state logic.
	always_comb begin
		phase_d      = phase_q;
		last_d       = last_q;
		still_move_d = still_move_q;
		still_turn_d = still_turn_q;
		prev_mask_d  = prev_mask_q;
		unique case (phase_q)
			PH_INIT: begin
				last_d  = now_s1;
				phase_d = PH_IDLE;
			end
			PH_IDLE: begin
				priority if (motion_pending) begin
					phase_d = PH_MOTION;
				end else if (mask_changed) begin
					phase_d = PH_KEYS;
				end else if (due) begin
					// Nothing to say: keep the send time one interval behind now.
					last_d = pulled_time;
				end else begin
					last_d = last_q;
				end
			end
			PH_MOTION: begin
				if (due) begin
					last_d = last_eff + TIME_WIDTH'(interval_q);
					if (!move_zero) begin
						still_move_d = '0;
					end else if (still_move_q != COUNT_MAX) begin
						still_move_d = still_move_q + 1'b1;
					end
					if (!turn_zero) begin
						still_turn_d = '0;
					end else if (still_turn_q != COUNT_MAX) begin
						still_turn_d = still_turn_q + 1'b1;
					end
					phase_d = mask_changed ? PH_KEYS : PH_IDLE;
				end
			end
			PH_KEYS: begin
				if (due) begin
					last_d      = last_eff + TIME_WIDTH'(interval_q);
					prev_mask_d = mask;
					phase_d     = PH_IDLE;
				end
			end
		endcase
	end

	// Output logic.
	always_comb begin
		sent_c      = 1'b0;
		report_id_c = RID_NONE;
		axes_on_c   = 1'b0;
		mask_on_c   = 1'b0;
		unique case (phase_q)
			PH_INIT, PH_IDLE: begin
			end
			PH_MOTION: begin
				if (due) begin
					sent_c      = 1'b1;
					report_id_c = RID_MOTION;
					axes_on_c   = 1'b1;
				end
			end
			PH_KEYS: begin
				if (due) begin
					sent_c      = 1'b1;
					report_id_c = RID_KEYS;
					mask_on_c   = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			last_q       <= '0;
			still_move_q <= '0;
			still_turn_q <= '0;
			prev_mask_q  <= '0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q      <= phase_d;
				last_q       <= last_d;
				still_move_q <= still_move_d;
				still_turn_q <= still_turn_d;
				prev_mask_q  <= prev_mask_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			sent_q      <= sent_c;
			report_id_q <= report_id_c;
			o_mx_q      <= axes_on_c ? move_x_s1 : '0;
			o_my_q      <= axes_on_c ? move_y_s1 : '0;
			o_mz_q      <= axes_on_c ? move_z_s1 : '0;
			o_tx_q      <= axes_on_c ? turn_x_s1 : '0;
			o_ty_q      <= axes_on_c ? turn_y_s1 : '0;
			o_tz_q      <= axes_on_c ? turn_z_s1 : '0;
			key_mask_q  <= mask_on_c ? mask : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sent       = sent_q;
	assign report_id  = report_id_q;
	assign out_move_x = o_mx_q;
	assign out_move_y = o_my_q;
	assign out_move_z = o_mz_q;
	assign out_turn_x = o_tx_q;
	assign out_turn_y = o_ty_q;
	assign out_turn_z = o_tz_q;
	assign key_mask   = key_mask_q;

endmodule

`default_nettype wire

@@ sv/mrp_keymap.sv @@
// Shortcut mask builder: turns the pressed keys into a 32-bit mask.
// Depends on mrp_pkg.
`default_nettype none

module mrp_keymap
	import mrp_pkg::*;
(
	input  wire keycfg_t                 cfg,
	input  wire logic [KEY_WIDTH-1:0]    keys,
	output logic      [MASK_WIDTH-1:0]   mask
);

	logic [15:0] keys_ext;
	logic [7:0]  bit_sel [NUM_KEYS];

	// Key positions beyond the input width read as released.
	assign keys_ext = 16'(keys);

	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (i == 0) begin
				bit_sel[i] = cfg.key_r_bit;
			end else if (i == 1) begin
				bit_sel[i] = cfg.key_l_bit;
			end else if (i == 2) begin
				bit_sel[i] = cfg.key_two_bit;
			end else if (i == 3) begin
				bit_sel[i] = cfg.key_one_bit;
			end else begin
				// Keys past the fourth land on bit zero.
				bit_sel[i] = 8'd0;
			end
		end
	end

	always_comb begin
		mask = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (keys_ext[i] && cfg.kill_rot_index != KILL_W'(i)
					&& cfg.kill_trans_index != KILL_W'(i)
					&& bit_sel[i] < 8'd32) begin
				mask = mask | (MASK_WIDTH'(1) << bit_sel[i][4:0]);
			end
		end
	end

endmodule

`default_nettype wire
